[hw/rtl/radix_n_signed_digit_alu_unit_defines.svh]
// Assertion macros for the radix-n signed-digit arithmetic unit.
// Used by radix_n_signed_digit_alu_unit.sv; depends on nothing else.
`ifndef RADIX_N_SIGNED_DIGIT_ALU_UNIT_DEFINES_SVH
`define RADIX_N_SIGNED_DIGIT_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RNSD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rnsd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RNSD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rnsd: next-cycle check failed");

`endif

[hw/rtl/rnsd_pkg.sv]
// Package for the radix-n signed-digit arithmetic unit: constants, codes,
// transaction structs and the sequencer state type. Depends on nothing.
package rnsd_pkg;

   localparam int DIGITS       = 8;
   localparam int FIELD_DIGITS = 8;
   localparam int USED         = (DIGITS < FIELD_DIGITS) ? DIGITS : FIELD_DIGITS;
   localparam int IDX_W        = (USED > 1) ? $clog2(USED) : 1;
   localparam int MAG_W        = 32;
   localparam int ALU_W        = MAG_W + 1;
   localparam int STEP_W       = $clog2(MAG_W);
   localparam int RADIX_W      = 5;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_OVERFLOW     = 2'd1,
      ST_ZERO_BY_ZERO = 2'd2,
      ST_DIV_BY_ZERO  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DEC_A,
      S_DEC_B,
      S_ARITH,
      S_MULDIV,
      S_FIX,
      S_ENC_RES,
      S_ENC_REM,
      S_DONE
   } state_type;

   typedef struct packed {
      action_type        action;
      logic              a_negative;
      logic [MAG_W-1:0]  a_digits;
      logic              b_negative;
      logic [MAG_W-1:0]  b_digits;
   } req_type;

   typedef struct packed {
      logic              result_negative;
      logic [MAG_W-1:0]  result_digits;
      logic              remainder_negative;
      logic [MAG_W-1:0]  remainder_digits;
      status_type        status;
   } rsp_type;

endpackage

[hw/rtl/rnsd_addsub.sv]
// Shared adder/subtractor of the radix-n arithmetic unit.
// Depends on rnsd_pkg for the operand width.
module rnsd_addsub (
   input  logic [rnsd_pkg::ALU_W-1:0] a,
   input  logic [rnsd_pkg::ALU_W-1:0] b,
   input  logic                       sub,
   output logic [rnsd_pkg::ALU_W:0]   y
);
   import rnsd_pkg::*;

   logic [ALU_W-1:0] b_eff;

   // For a subtraction the top bit of y is set when a is not below b.
   assign b_eff = sub ? ~b : b;
   assign y = {1'b0, a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, sub};

endmodule

[hw/rtl/radix_n_signed_digit_alu_unit.sv]
// Radix-n signed-digit unit: add, subtract, multiply and Euclidean divide.
// The digit decode, the bit-serial multiply/divide loop and the four-step-per-digit
// encode run in sequence; the loop and the encode share one adder. A new
// transaction is taken the cycle after the strobe. Synchronous reset idles the
// sequencer and sets the radix to 10.
`include "radix_n_signed_digit_alu_unit_defines.svh"

module radix_n_signed_digit_alu_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  rnsd_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output rnsd_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [rnsd_pkg::RADIX_W-1:0]    csr_wdata
);
   import rnsd_pkg::*;

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(USED - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);
   localparam int                PRE_SHIFT = 4 * (FIELD_DIGITS - USED);

   state_type            state_ff, state_in;
   logic [RADIX_W-1:0]   radix_ff;
   logic [IDX_W-1:0]     cnt_ff;
   logic [1:0]           bit_ff;
   logic [STEP_W-1:0]    step_ff;
   action_type           act_ff;
   logic                 a_neg_ff, b_neg_ff;
   logic [MAG_W-1:0]     a_sh_ff, b_sh_ff;
   logic [MAG_W-1:0]     ma_ff, mb_ff;
   logic [MAG_W:0]       pw_ff;
   logic [MAG_W-1:0]     pow_ff [USED];
   logic [MAG_W-1:0]     lim_ff;
   logic [MAG_W:0]       hi_ff;
   logic [MAG_W-1:0]     lo_ff;
   logic                 res_neg_ff;
   logic [MAG_W-1:0]     rem_mag_ff;
   status_type           status_ff;
   logic [MAG_W-1:0]     enc_v_ff;
   logic [MAG_W-1:0]     word_ff, res_word_ff, rem_word_ff;

   logic [3:0]           dig4;
   logic [RADIX_W-1:0]   dig_raw, dig_sat;
   logic [MAG_W-1:0]     dec_src;
   logic [MAG_W+4:0]     dec_prod;
   logic [MAG_W+5:0]     pw_prod;

   logic [ALU_W-1:0]     alu_a, alu_b;
   logic                 alu_sub;
   logic [ALU_W:0]       alu_y;
   logic [ALU_W-1:0]     rem_sh, trial;
   logic                 alu_ge;

   logic                 na, nb;
   logic signed [MAG_W+1:0] sa, sb, sr;
   logic [MAG_W:0]       rmag;
   logic [MAG_W-1:0]     q_fix, r_fix;
   logic                 fin_neg;
   logic [MAG_W-1:0]     fin_mag, fin_rem;
   status_type           fin_status;

   logic                 enc_end;
   logic [MAG_W-1:0]     word_nx;

   logic                 rsp_failed, rsp_cleared, radix_ok;

   rnsd_addsub u_addsub (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .y   (alu_y)
   );

   // Digit decode: one digit a cycle, v = v * radix + saturated digit.
   assign dig4    = (state_ff == S_DEC_A) ? a_sh_ff[MAG_W-1 -: 4] : b_sh_ff[MAG_W-1 -: 4];
   assign dig_raw = {1'b0, dig4};
   assign dig_sat = (dig_raw >= radix_ff) ? radix_ff - 5'd1 : dig_raw;
   assign dec_src = (state_ff == S_DEC_A) ? ma_ff : mb_ff;
   assign dec_prod = {5'b0, dec_src} * {{MAG_W{1'b0}}, radix_ff}
                   + {{MAG_W{1'b0}}, dig_sat};
   assign pw_prod = {5'b0, pw_ff} * {{(MAG_W+1){1'b0}}, radix_ff};

   assign rem_sh = {hi_ff[MAG_W-1:0], lo_ff[MAG_W-1]};
   assign trial  = {1'b0, pow_ff[cnt_ff]} << bit_ff;
   assign alu_ge = alu_y[ALU_W];

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff) inside
         S_MULDIV: begin
            if (act_ff == ACT_MUL) begin
               alu_a = hi_ff;
               alu_b = {1'b0, ma_ff};
            end else begin
               alu_a   = rem_sh;
               alu_b   = {1'b0, mb_ff};
               alu_sub = 1'b1;
            end
         end
         S_ENC_RES, S_ENC_REM: begin
            alu_a   = {1'b0, enc_v_ff};
            alu_b   = trial;
            alu_sub = 1'b1;
         end
         default: begin
            alu_a   = '0;
         end
      endcase
   end

   // Final result selection, used in the arithmetic and fix-up cycles.
   assign na = a_neg_ff && (ma_ff != '0);
   assign nb = b_neg_ff && (mb_ff != '0);
   assign sa = na ? -$signed({2'b00, ma_ff}) : $signed({2'b00, ma_ff});
   assign sb = nb ? -$signed({2'b00, mb_ff}) : $signed({2'b00, mb_ff});
   assign sr = (act_ff == ACT_SUB) ? sa - sb : sa + sb;
   assign rmag = (sr < 0) ? MAG_W'(0) + (MAG_W+1)'(-sr) : (MAG_W+1)'(sr);

   always_comb begin
      q_fix = lo_ff;
      r_fix = hi_ff[MAG_W-1:0];
      // A negative dividend with a remainder rounds the quotient away from zero.
      if (na && (hi_ff[MAG_W-1:0] != '0)) begin
         q_fix = lo_ff + 32'd1;
         r_fix = mb_ff - hi_ff[MAG_W-1:0];
      end
   end

   always_comb begin
      fin_status = ST_OK;
      fin_neg    = 1'b0;
      fin_mag    = '0;
      fin_rem    = '0;
      case (act_ff) inside
         ACT_ADD, ACT_SUB: begin
            if (rmag > {1'b0, lim_ff}) begin
               fin_status = ST_OVERFLOW;
            end else begin
               fin_mag = rmag[MAG_W-1:0];
               fin_neg = (sr < 0);
            end
         end
         ACT_MUL: begin
            if ((hi_ff != '0) || (lo_ff > lim_ff)) begin
               fin_status = ST_OVERFLOW;
            end else begin
               fin_mag = lo_ff;
               fin_neg = (na ^ nb) && (lo_ff != '0);
            end
         end
         default: begin
            if (mb_ff == '0) begin
               fin_status = (ma_ff == '0) ? ST_ZERO_BY_ZERO : ST_DIV_BY_ZERO;
            end else if (q_fix > lim_ff) begin
               fin_status = ST_OVERFLOW;
            end else begin
               fin_mag = q_fix;
               fin_rem = r_fix;
               fin_neg = (na ^ nb) && (q_fix != '0);
            end
         end
      endcase
   end

   // Encode: digits from the top, each found by four trial subtractions.
   assign enc_end = (bit_ff == 2'd0) && (cnt_ff == '0);
   always_comb begin
      word_nx = word_ff;
      word_nx[{cnt_ff, bit_ff}] = alu_ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         radix_ff <= RADIX_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_wdata < RADIX_MIN) begin
               radix_ff <= RADIX_MIN;
            end else if (csr_wdata > RADIX_MAX) begin
               radix_ff <= RADIX_MAX;
            end else begin
               radix_ff <= csr_wdata;
            end
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      busy      = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_DONE);
      unique case (state_ff)
         S_IDLE:    if (start) state_in = S_DEC_A;
         S_DEC_A:   if (cnt_ff == LAST_IDX) state_in = S_DEC_B;
         S_DEC_B:   if (cnt_ff == LAST_IDX) state_in = S_ARITH;
         S_ARITH: begin
            if ((act_ff == ACT_ADD) || (act_ff == ACT_SUB)) begin
               state_in = S_ENC_RES;
            end else begin
               state_in = S_MULDIV;
            end
         end
         S_MULDIV:  if (step_ff == LAST_STEP) state_in = S_FIX;
         S_FIX:     state_in = S_ENC_RES;
         S_ENC_RES: if (enc_end) state_in = S_ENC_REM;
         S_ENC_REM: if (enc_end) state_in = S_DONE;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_ff   <= req_data.action;
               a_neg_ff <= req_data.a_negative;
               b_neg_ff <= req_data.b_negative;
               a_sh_ff  <= req_data.a_digits << PRE_SHIFT;
               b_sh_ff  <= req_data.b_digits << PRE_SHIFT;
               ma_ff    <= '0;
               mb_ff    <= '0;
               pw_ff    <= (MAG_W+1)'(1);
               cnt_ff   <= '0;
            end
         end
         S_DEC_A: begin
            pow_ff[cnt_ff] <= pw_ff[MAG_W-1:0];
            pw_ff   <= pw_prod[MAG_W:0];
            ma_ff   <= dec_prod[MAG_W-1:0];
            a_sh_ff <= a_sh_ff << 4;
            cnt_ff  <= (cnt_ff == LAST_IDX) ? '0 : cnt_ff + 1'b1;
         end
         S_DEC_B: begin
            lim_ff  <= MAG_W'(pw_ff - (MAG_W+1)'(1));
            mb_ff   <= dec_prod[MAG_W-1:0];
            b_sh_ff <= b_sh_ff << 4;
            cnt_ff  <= (cnt_ff == LAST_IDX) ? '0 : cnt_ff + 1'b1;
         end
         S_ARITH: begin
            hi_ff      <= '0;
            lo_ff      <= (act_ff == ACT_MUL) ? mb_ff : ma_ff;
            step_ff    <= '0;
            res_neg_ff <= fin_neg;
            rem_mag_ff <= fin_rem;
            status_ff  <= fin_status;
            enc_v_ff   <= fin_mag;
            word_ff    <= '0;
            cnt_ff     <= LAST_IDX;
            bit_ff     <= 2'd3;
         end
         S_MULDIV: begin
            step_ff <= step_ff + 1'b1;
            if (act_ff == ACT_MUL) begin
               if (lo_ff[0]) begin
                  hi_ff <= {1'b0, alu_y[MAG_W:1]};
                  lo_ff <= {alu_y[0], lo_ff[MAG_W-1:1]};
               end else begin
                  hi_ff <= {1'b0, hi_ff[MAG_W:1]};
                  lo_ff <= {hi_ff[0], lo_ff[MAG_W-1:1]};
               end
            end else begin
               hi_ff <= alu_ge ? alu_y[MAG_W:0] : rem_sh;
               lo_ff <= {lo_ff[MAG_W-2:0], alu_ge};
            end
         end
         S_FIX: begin
            res_neg_ff <= fin_neg;
            rem_mag_ff <= fin_rem;
            status_ff  <= fin_status;
            enc_v_ff   <= fin_mag;
            word_ff    <= '0;
            cnt_ff     <= LAST_IDX;
            bit_ff     <= 2'd3;
         end
         S_ENC_RES, S_ENC_REM: begin
            if (enc_end) begin
               cnt_ff  <= LAST_IDX;
               bit_ff  <= 2'd3;
               word_ff <= '0;
               if (state_ff == S_ENC_RES) begin
                  res_word_ff <= word_nx;
                  enc_v_ff    <= rem_mag_ff;
               end else begin
                  rem_word_ff <= word_nx;
               end
            end else begin
               if (alu_ge) begin
                  enc_v_ff <= alu_y[MAG_W-1:0];
               end
               word_ff <= word_nx;
               if (bit_ff == 2'd0) begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
               bit_ff <= bit_ff - 2'd1;
            end
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   assign rsp_data.result_negative    = res_neg_ff;
   assign rsp_data.result_digits      = res_word_ff;
   assign rsp_data.remainder_negative = 1'b0;
   assign rsp_data.remainder_digits   = rem_word_ff;
   assign rsp_data.status             = status_ff;

   assign rsp_failed  = rsp_valid && (rsp_data.status != ST_OK);
   assign rsp_cleared = (rsp_data.result_digits == '0) && (rsp_data.remainder_digits == '0)
                        && !rsp_data.result_negative;
   assign radix_ok    = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);

   // A failed transaction carries no magnitude and no sign.
   `RNSD_ASSERT_IMP(a_fail_clears, clock, reset, rsp_failed, rsp_cleared)
   `RNSD_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy)
   `RNSD_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid && !busy)
   `RNSD_ASSERT_IMP(a_radix_range, clock, reset, 1'b1, radix_ok)

endmodule

[verif/tb_radix_n_signed_digit_alu_unit.sv]
// Self-checking testbench for the radix-n signed-digit arithmetic unit: random and directed
// transactions are checked against an in-bench predictor over several radix settings.
// Depends on rnsd_pkg and radix_n_signed_digit_alu_unit only.
module tb_radix_n_signed_digit_alu_unit;
   import rnsd_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [RADIX_W-1:0] csr_wdata = '0;

   radix_n_signed_digit_alu_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   req_type pending_ops[$];
   rsp_type expected_rsps[$];
   int unsigned model_radix = 10;
   int unsigned failures = 0;
   int unsigned cycle_count = 0;
   bit took = 1'b0;
   bit hold_off = 1'b0;
   bit no_gaps = 1'b0;
   int unsigned gap = 0;

   // Magnitude of a packed operand; digits at or above the radix saturate.
   function automatic longint unsigned digits_value(logic [MAG_W-1:0] p, int unsigned rdx);
      longint unsigned v;
      int unsigned d;
      v = 0;
      for (int i = USED - 1; i >= 0; i--) begin
         d = 32'(p[4*i +: 4]);
         if (d >= rdx) d = rdx - 1;
         v = v * rdx + d;
      end
      return v;
   endfunction

   function automatic logic [MAG_W-1:0] pack_digits(longint unsigned v, int unsigned rdx);
      logic [MAG_W-1:0] p;
      p = '0;
      for (int i = 0; i < USED; i++) begin
         p[4*i +: 4] = 4'(v % rdx);
         v = v / rdx;
      end
      return p;
   endfunction

   function automatic rsp_type predict_alu(req_type r, int unsigned rdx);
      rsp_type o;
      longint unsigned ma, mb, lim, rmag, remmag, q;
      longint sr;
      bit na, nb, rneg;
      status_type st;
      ma = digits_value(r.a_digits, rdx);
      mb = digits_value(r.b_digits, rdx);
      na = r.a_negative && ma != 0;
      nb = r.b_negative && mb != 0;
      lim = 1;
      for (int i = 0; i < USED; i++) lim = lim * rdx;
      lim = lim - 1;
      rneg = 1'b0;
      rmag = 0;
      remmag = 0;
      st = ST_OK;
      case (r.action) inside
         ACT_ADD, ACT_SUB: begin
            sr = (na ? -longint'(ma) : longint'(ma)) +
                 ((r.action == ACT_ADD) != nb ? longint'(mb) : -longint'(mb));
            rneg = sr < 0;
            rmag = rneg ? longint'(-sr) : sr;
         end
         ACT_MUL: begin
            rmag = ma * mb;
            rneg = (na != nb) && rmag != 0;
         end
         default: begin
            if (mb == 0) begin
               st = (ma == 0) ? ST_ZERO_BY_ZERO : ST_DIV_BY_ZERO;
            end else begin
               q = ma / mb;
               remmag = ma % mb;
               // Euclidean: a negative dividend rounds the quotient away from zero.
               if (na && remmag != 0) begin
                  q = q + 1;
                  remmag = mb - remmag;
               end
               rmag = q;
               rneg = (na != nb) && q != 0;
            end
         end
      endcase
      if (st == ST_OK && rmag > lim) st = ST_OVERFLOW;
      if (st != ST_OK) begin
         rneg = 1'b0;
         rmag = 0;
         remmag = 0;
      end
      o.result_negative = rneg;
      o.result_digits = pack_digits(rmag, rdx);
      o.remainder_negative = 1'b0;
      o.remainder_digits = pack_digits(remmag, rdx);
      o.status = st;
      return o;
   endfunction

   // Acceptance, prediction and result checking, all on the rising edge.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("radix_n_signed_digit_alu_unit regression: fail");
         $finish;
      end
      took = !reset && start && !busy;
      if (took) begin
         expected_rsps.push_back(predict_alu(req_data, model_radix));
         void'(pending_ops.pop_front());
      end
      if (!reset && csr_we)
         model_radix = 32'((csr_wdata < RADIX_MIN) ? RADIX_MIN :
                           (csr_wdata > RADIX_MAX) ? RADIX_MAX : csr_wdata);
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: expected no result, actual %p", $time, rsp_data);
            failures++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (e.result_negative !== rsp_data.result_negative ||
                e.result_digits !== rsp_data.result_digits ||
                e.remainder_negative !== rsp_data.remainder_negative ||
                e.remainder_digits !== rsp_data.remainder_digits ||
                e.status !== rsp_data.status) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
               failures++;
            end
         end
      end
   end

   // Driver: presents the head of the pending queue after a random gap, or with none when no_gaps is set.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !took) begin
         start <= 1'b1;
      end else if (gap > 0) begin
         gap <= gap - 1;
         start <= 1'b0;
      end else if (pending_ops.size() > 0 && !hold_off) begin
         req_data <= pending_ops[0];
         start <= 1'b1;
         gap <= no_gaps ? 0 : $urandom_range(0, 6);
      end else begin
         start <= 1'b0;
      end
   end

   function automatic logic [MAG_W-1:0] random_operand(int unsigned rdx);
      logic [MAG_W-1:0] p;
      int unsigned width;
      p = $urandom;
      width = $urandom_range(1, USED);
      for (int i = 0; i < USED; i++) begin
         if (i >= width && $urandom_range(0, 3) != 0) p[4*i +: 4] = 4'd0;
         else if ($urandom_range(0, 9) != 0) p[4*i +: 4] = 4'($urandom_range(0, rdx - 1));
      end
      return p;
   endfunction

   function automatic req_type make_op(action_type a, bit an, logic [MAG_W-1:0] ad,
                                       bit bn, logic [MAG_W-1:0] bd);
      req_type r;
      r.action = a;
      r.a_negative = an;
      r.a_digits = ad;
      r.b_negative = bn;
      r.b_digits = bd;
      return r;
   endfunction

   task automatic wait_idle();
      wait (pending_ops.size() == 0 && expected_rsps.size() == 0);
      repeat (5) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_radix(logic [RADIX_W-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++)
         pending_ops.push_back(make_op(action_type'($urandom_range(0, 3)),
            1'($urandom_range(0, 1)), random_operand(model_radix),
            1'($urandom_range(0, 1)), random_operand(model_radix)));
   endtask

   initial begin
      logic [RADIX_W-1:0] radices[$];
      radices = {5'd2, 5'd16, 5'd0, 5'd31, 5'd3, 5'd1, 5'd17, 5'd7, 5'd9, 5'd10};
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      write_radix(5'd10);

      // Directed transactions at radix ten.
      pending_ops.push_back(make_op(ACT_ADD, 1'b0, 32'h0, 1'b1, 32'h0));
      pending_ops.push_back(make_op(ACT_ADD, 1'b0, 32'h99999999, 1'b0, 32'h1));
      pending_ops.push_back(make_op(ACT_ADD, 1'b1, 32'h99999999, 1'b1, 32'h99999999));
      pending_ops.push_back(make_op(ACT_ADD, 1'b1, 32'h5, 1'b0, 32'h3));
      pending_ops.push_back(make_op(ACT_SUB, 1'b0, 32'h3, 1'b0, 32'h5));
      pending_ops.push_back(make_op(ACT_SUB, 1'b1, 32'h99999999, 1'b0, 32'h99999999));
      pending_ops.push_back(make_op(ACT_SUB, 1'b1, 32'h0, 1'b1, 32'h0));
      pending_ops.push_back(make_op(ACT_MUL, 1'b1, 32'h12345, 1'b0, 32'h678));
      pending_ops.push_back(make_op(ACT_MUL, 1'b0, 32'h99999999, 1'b0, 32'h99999999));
      pending_ops.push_back(make_op(ACT_MUL, 1'b1, 32'h0, 1'b0, 32'h77));
      pending_ops.push_back(make_op(ACT_MUL, 1'b1, 32'hFFFFFFFF, 1'b1, 32'h1));
      pending_ops.push_back(make_op(ACT_DIV, 1'b0, 32'h0, 1'b1, 32'h0));
      pending_ops.push_back(make_op(ACT_DIV, 1'b1, 32'h7, 1'b0, 32'h0));
      pending_ops.push_back(make_op(ACT_DIV, 1'b1, 32'h7, 1'b0, 32'h2));
      pending_ops.push_back(make_op(ACT_DIV, 1'b1, 32'h7, 1'b1, 32'h2));
      pending_ops.push_back(make_op(ACT_DIV, 1'b0, 32'h7, 1'b1, 32'h2));
      pending_ops.push_back(make_op(ACT_DIV, 1'b1, 32'h6, 1'b0, 32'h3));
      pending_ops.push_back(make_op(ACT_DIV, 1'b0, 32'h99999999, 1'b0, 32'h1));
      pending_ops.push_back(make_op(ACT_DIV, 1'b1, 32'h1, 1'b0, 32'h99999999));
      pending_ops.push_back(make_op(ACT_DIV, 1'b0, 32'hFFFFFFFF, 1'b0, 32'hAAAAAAAA));
      wait_idle();

      foreach (radices[k]) begin
         write_radix(radices[k]);
         @(negedge clock);
         no_gaps = (k % 3 == 1);
         random_phase(50);
         // Stall the sender mid-phase until every outstanding result is back.
         wait (pending_ops.size() == 0);
         hold_off = 1'b1;
         random_phase(50);
         wait (expected_rsps.size() == 0);
         hold_off = 1'b0;
         wait_idle();
      end

      repeat (200) @(negedge clock);
      if (failures == 0)
         $display("radix_n_signed_digit_alu_unit regression: pass");
      else
         $display("radix_n_signed_digit_alu_unit regression: fail");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rnsd_pkg.sv
hw/rtl/rnsd_addsub.sv
hw/rtl/radix_n_signed_digit_alu_unit.sv
verif/tb_radix_n_signed_digit_alu_unit.sv
